// ===== rtl/core/wev_pkg.sv =====
`timescale 1ns / 1ps

package wev_pkg;

  // Default sizing of the history ring and the number of wheels.
  localparam int unsigned HISTORY_DEPTH_DEF = 16;
  localparam int unsigned WHEEL_COUNT_DEF   = 4;

  // Field widths.
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned SPEED_W   = 32;
  localparam int unsigned MPT_W     = 32;
  localparam int unsigned WIN_W     = 4;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [MPT_W-1:0] MPT_RESET       = 32'd429497;
  localparam logic [WIN_W-1:0] SHORT_WIN_RESET = 4'd1;
  localparam logic [WIN_W-1:0] LONG_WIN_RESET  = 4'd10;

  // Arithmetic of one speed lane.
  localparam int unsigned SCALE_W    = 20;
  localparam logic [SCALE_W-1:0] US_PER_S = 20'd1000000;
  localparam int unsigned MAG_W      = CNT_W + 1;
  localparam int unsigned PROD_W     = CNT_W + MPT_W;
  localparam int unsigned FULL_W     = PROD_W + SCALE_W;
  localparam int unsigned FRAC_DROP  = 16;
  localparam int unsigned SCALED_W   = FULL_W - FRAC_DROP;
  localparam int unsigned QUO_W      = SPEED_W - 1;
  localparam int unsigned TOP_W      = SCALED_W - QUO_W;
  localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

  // Step counts of the serial phases.
  localparam int unsigned MUL_A_STEPS = MPT_W;
  localparam int unsigned MUL_B_STEPS = SCALE_W;
  localparam int unsigned DIV_STEPS   = QUO_W;
  localparam int unsigned STEP_W      = $clog2(MUL_A_STEPS);

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_MPT       = 2'd0,
    REG_SHORT_WIN = 2'd1,
    REG_LONG_WIN  = 2'd2
  } cfg_reg_t;

  // Operation applied to every lane in a cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_MUL_A,
    OP_MUL_B,
    OP_DIV_SET,
    OP_DIV
  } lane_op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_SHORT,
    ST_RD_LONG,
    ST_LOAD,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_SET,
    ST_DIV,
    ST_FIN
  } seq_state_t;

  // Controls from the sequencer to the ring and the lanes.
  typedef struct packed {
    logic     rd_en;
    logic     rd_long;
    logic     cap_short;
    lane_op_t op;
    logic     fin;
  } seq_ctrl_t;

endpackage

// ===== rtl/core/wev_ram.sv =====
`timescale 1ns / 1ps

module wev_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/wev_lane.sv =====
`timescale 1ns / 1ps

module wev_lane (
  input  logic                            clk,
  input  wev_pkg::lane_op_t               op,
  input  logic [wev_pkg::CNT_W-1:0]       cur_count,
  input  logic [wev_pkg::CNT_W-1:0]       old_count,
  input  logic [wev_pkg::TIME_W-1:0]      cur_time,
  input  logic [wev_pkg::TIME_W-1:0]      old_time,
  input  logic                            empty_win,
  input  logic [wev_pkg::MPT_W-1:0]       mpt,
  output logic [wev_pkg::SPEED_W-1:0]     speed
);

  import wev_pkg::*;

  // Operands captured at load.
  logic              neg_r;
  logic              zero_r;
  logic [MAG_W-1:0]  mag_r;
  logic [TIME_W-1:0] dt_r;

  // Shift-add multiplier by meters per tick, one multiplier bit per cycle.
  logic [MAG_W-1:0]  pa_hi_r;
  logic [MPT_W-1:0]  pa_lo_r;

  // Shift-add multiplier by one million, one constant bit per cycle.
  logic [PROD_W-1:0]  pb_hi_r;
  logic [SCALE_W-1:0] pb_lo_r;

  // Restoring divider, one quotient bit per cycle.
  logic              ovf_r;
  logic [TIME_W-1:0] rem_r;
  logic [QUO_W-1:0]  quo_r;

  logic [MAG_W-1:0]    delta;
  logic [MAG_W-1:0]    mag;
  logic [TIME_W-1:0]   dt;
  logic [MAG_W:0]      sum_a;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     sum_b;
  logic [FULL_W-1:0]   full;
  logic [SCALED_W-1:0] scaled;
  logic [TOP_W-1:0]    top;
  logic [TIME_W:0]     trial;
  logic                ge;

  // Exact count difference and elapsed time over the window.
  assign delta = {cur_count[CNT_W-1], cur_count} - {old_count[CNT_W-1], old_count};
  assign mag   = delta[MAG_W-1] ? (MAG_W'(0) - delta) : delta;
  assign dt    = cur_time - old_time;

  // Partial sums of the two multipliers.
  assign sum_a = {1'b0, pa_hi_r} + (pa_lo_r[0] ? {1'b0, mag_r} : '0);
  assign prod  = {pa_hi_r[CNT_W-1:0], pa_lo_r};
  assign sum_b = {1'b0, pb_hi_r} + (pb_lo_r[0] ? {1'b0, prod} : '0);

  // Dividend with the 2^16 scale of the divisor folded in.
  assign full   = {pb_hi_r, pb_lo_r};
  assign scaled = full[FULL_W-1:FRAC_DROP];
  assign top    = scaled[SCALED_W-1:QUO_W];

  // One restoring step.
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, dt_r};

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        mag_r   <= mag;
        neg_r   <= delta[MAG_W-1];
        dt_r    <= dt;
        zero_r  <= empty_win || (dt == '0);
        pa_hi_r <= '0;
        pa_lo_r <= mpt;
        pb_hi_r <= '0;
        pb_lo_r <= US_PER_S;
      end
      OP_MUL_A: begin
        pa_hi_r <= sum_a[MAG_W:1];
        pa_lo_r <= {sum_a[0], pa_lo_r[MPT_W-1:1]};
      end
      OP_MUL_B: begin
        pb_hi_r <= sum_b[PROD_W:1];
        pb_lo_r <= {sum_b[0], pb_lo_r[SCALE_W-1:1]};
      end
      OP_DIV_SET: begin
        // A quotient of 2^31 or more saturates whatever the low bits are.
        ovf_r <= top >= TOP_W'(dt_r);
        rem_r <= top[TIME_W-1:0];
        quo_r <= scaled[QUO_W-1:0];
      end
      OP_DIV: begin
        rem_r <= ge ? TIME_W'(trial - {1'b0, dt_r}) : trial[TIME_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  // Signed, saturated speed.
  always_comb begin
    if (zero_r) begin
      speed = '0;
    end else if (ovf_r) begin
      speed = neg_r ? SPEED_MIN : SPEED_MAX;
    end else if (neg_r) begin
      speed = SPEED_W'(0) - SPEED_W'(quo_r);
    end else begin
      speed = SPEED_W'(quo_r);
    end
  end

endmodule

// ===== rtl/core/wev_seq.sv =====
`timescale 1ns / 1ps

module wev_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               out_free,
  output logic               in_ready,
  output wev_pkg::seq_ctrl_t ctrl
);

  import wev_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // State and step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Two ring reads, operand load, then the serial phases of the lanes.
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    ctrl.rd_en     = 1'b0;
    ctrl.rd_long   = 1'b0;
    ctrl.cap_short = 1'b0;
    ctrl.op        = OP_HOLD;
    ctrl.fin       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RD_SHORT;
        end
      end
      ST_RD_SHORT: begin
        ctrl.rd_en = 1'b1;
        state_nxt  = ST_RD_LONG;
      end
      ST_RD_LONG: begin
        ctrl.rd_en     = 1'b1;
        ctrl.rd_long   = 1'b1;
        ctrl.cap_short = 1'b1;
        state_nxt      = ST_LOAD;
      end
      ST_LOAD: begin
        ctrl.op   = OP_LOAD;
        step_nxt  = STEP_W'(MUL_A_STEPS - 1);
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        ctrl.op = OP_MUL_A;
        if (step_r == '0) begin
          step_nxt  = STEP_W'(MUL_B_STEPS - 1);
          state_nxt = ST_MUL_B;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_MUL_B: begin
        ctrl.op = OP_MUL_B;
        if (step_r == '0) begin
          state_nxt = ST_DIV_SET;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_DIV_SET: begin
        ctrl.op   = OP_DIV_SET;
        step_nxt  = STEP_W'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        ctrl.op = OP_DIV;
        if (step_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ctrl.fin  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  // The multiply phase starts with its full step count.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |=> state_r == ST_MUL_A && step_r == STEP_W'(MUL_A_STEPS - 1))
    else $error("multiply phase entered with a wrong step count");

  // The last divide step hands over to the result stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && step_r == '0 |=> state_r == ST_FIN)
    else $error("divide phase did not end on its last step");

endmodule

// ===== rtl/core/windowed_encoder_velocity.sv =====
`timescale 1ns / 1ps

// Wheel speed estimator. Each input transfer carries one control period: the
// absolute count of every wheel (tdata from bit 0 up: count_wheel0 ..
// count_wheel3, then elapsed_us) and the microseconds since the last period.
// The block keeps a running time total, stores counts and time in a history
// ring of HISTORY_DEPTH periods and returns one result transfer per period
// with a short-window and a long-window speed for every wheel, in units of
// 2^-16 m/s, truncated toward zero and saturated to 32 bits. A window is cut
// to the number of stored periods minus one; an empty window or a zero time
// difference gives zero. Registers: meters_per_tick at 0x0 (2^-32 m per
// tick), short_window at 0x4, long_window at 0x8, to be written only while
// the block is idle; the block itself does not enforce this. A period goes
// from its input transfer to the next possible one through two ring reads,
// an operand load, the bit-serial multiply by meters_per_tick and the one
// by one million, the restoring divide (an overflow check and 31 quotient
// steps), the move of the result into the output register once an earlier
// result has been taken, and the idle state that takes the next transfer,
// with all 2*WHEEL_COUNT speed lanes running side by side. The next period
// is accepted while a finished result still waits in the output register.
module windowed_encoder_velocity #(
  parameter int unsigned HISTORY_DEPTH = wev_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned WHEEL_COUNT   = wev_pkg::WHEEL_COUNT_DEF,
  localparam int unsigned IN_W =
    ((wev_pkg::CNT_W * WHEEL_COUNT + wev_pkg::ELAPSED_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = 2 * WHEEL_COUNT * wev_pkg::SPEED_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // From bit 0: count_wheel0 .. count_wheel(N-1), elapsed_us, zero fill.
  input  logic [IN_W-1:0]                  in_tdata,
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // From bit 0: short_speed0 .. short_speed(N-1), long_speed0 .. long_speed(N-1).
  output logic [OUT_W-1:0]                 out_tdata,
  // Configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [wev_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [wev_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [wev_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  import wev_pkg::*;

  localparam int unsigned AW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned UW    = (FW > WIN_W) ? FW : WIN_W;
  localparam int unsigned UW1   = UW + 1;
  localparam int unsigned CNTS_W = CNT_W * WHEEL_COUNT;
  localparam int unsigned ROW_W = CNTS_W + TIME_W;
  localparam int unsigned LANES = 2 * WHEEL_COUNT;

  // Configuration registers.
  logic [MPT_W-1:0] mpt_r;
  logic [WIN_W-1:0] short_win_r;
  logic [WIN_W-1:0] long_win_r;

  // Ring bookkeeping.
  logic [TIME_W-1:0] time_total_r, time_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [ROW_W-1:0]  cur_row_r;
  logic [ROW_W-1:0]  row_short_r;
  logic [ROW_W-1:0]  row_in;
  logic [ROW_W-1:0]  ram_rdata;

  // Windows and the ring entries they reach back to.
  logic [UW-1:0] span_short, span_long;
  logic [AW-1:0] old_short, old_long;

  // Output register.
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;
  logic             out_free;

  logic      in_acc;
  logic      cfg_wr;
  seq_ctrl_t ctrl;
  logic [SPEED_W-1:0] speed [LANES];

  // Effective span of a window given the fill level.
  function automatic logic [UW-1:0] win_span(input logic [WIN_W-1:0] win,
                                             input logic [FW-1:0] fill);
    logic [UW-1:0] w_ext;
    logic [UW-1:0] f_ext;
    w_ext = UW'(win);
    f_ext = UW'(fill);
    if (f_ext <= UW'(1)) begin
      return '0;
    end else if (w_ext > f_ext - UW'(1)) begin
      return f_ext - UW'(1);
    end
    return w_ext;
  endfunction

  // Ring index a given number of periods behind the head.
  function automatic logic [AW-1:0] back_index(input logic [AW-1:0] head,
                                               input logic [UW-1:0] span_v);
    logic [UW1-1:0] h_ext;
    logic [UW1-1:0] s_ext;
    logic [UW1-1:0] idx;
    h_ext = UW1'(head);
    s_ext = UW1'(span_v);
    if (h_ext >= s_ext) begin
      idx = h_ext - s_ext;
    end else begin
      idx = h_ext + UW1'(HISTORY_DEPTH) - s_ext;
    end
    return idx[AW-1:0];
  endfunction

  assign in_acc = in_tvalid && in_tready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r       <= MPT_RESET;
      short_win_r <= SHORT_WIN_RESET;
      long_win_r  <= LONG_WIN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_paddr[3:2]))
        REG_MPT:       mpt_r       <= cfg_pwdata[MPT_W-1:0];
        REG_SHORT_WIN: short_win_r <= cfg_pwdata[WIN_W-1:0];
        REG_LONG_WIN:  long_win_r  <= cfg_pwdata[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration reads.
  always_comb begin
    unique case (cfg_reg_t'(cfg_paddr[3:2]))
      REG_MPT:       cfg_prdata = CFG_DATA_W'(mpt_r);
      REG_SHORT_WIN: cfg_prdata = CFG_DATA_W'(short_win_r);
      REG_LONG_WIN:  cfg_prdata = CFG_DATA_W'(long_win_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // Next time total, head and fill level of an accepted period.
  assign time_nxt = time_total_r + TIME_W'(in_tdata[CNTS_W +: ELAPSED_W]);
  assign head_nxt = (head_r == AW'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign fill_nxt = (fill_r < FW'(HISTORY_DEPTH)) ? fill_r + 1'b1 : fill_r;
  assign row_in   = {time_nxt, in_tdata[CNTS_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_total_r <= '0;
      head_r       <= '0;
      fill_r       <= '0;
    end else if (in_acc) begin
      time_total_r <= time_nxt;
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
    end
  end

  // The newest row is held in registers; older rows come from the ring.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_row_r <= row_in;
    end
    if (ctrl.cap_short) begin
      row_short_r <= ram_rdata;
    end
  end

  assign span_short = win_span(short_win_r, fill_r);
  assign span_long  = win_span(long_win_r, fill_r);
  assign old_short  = back_index(head_r, span_short);
  assign old_long   = back_index(head_r, span_long);

  // History ring: one row per period, counts low and time total high.
  wev_ram #(
    .WIDTH (ROW_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (head_nxt),
    .wdata (row_in),
    .re    (ctrl.rd_en),
    .raddr (ctrl.rd_long ? old_long : old_short),
    .rdata (ram_rdata)
  );

  wev_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctrl     (ctrl)
  );

  // Short-window lanes first, then long-window lanes.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    localparam int unsigned WHEEL = k % WHEEL_COUNT;
    if (k < WHEEL_COUNT) begin : g_short
      wev_lane u_lane (
        .clk       (clk),
        .op        (ctrl.op),
        .cur_count (cur_row_r[CNT_W*WHEEL +: CNT_W]),
        .old_count (row_short_r[CNT_W*WHEEL +: CNT_W]),
        .cur_time  (cur_row_r[CNTS_W +: TIME_W]),
        .old_time  (row_short_r[CNTS_W +: TIME_W]),
        .empty_win (span_short == '0),
        .mpt       (mpt_r),
        .speed     (speed[k])
      );
    end else begin : g_long
      wev_lane u_lane (
        .clk       (clk),
        .op        (ctrl.op),
        .cur_count (cur_row_r[CNT_W*WHEEL +: CNT_W]),
        .old_count (ram_rdata[CNT_W*WHEEL +: CNT_W]),
        .cur_time  (cur_row_r[CNTS_W +: TIME_W]),
        .old_time  (ram_rdata[CNTS_W +: TIME_W]),
        .empty_win (span_long == '0),
        .mpt       (mpt_r),
        .speed     (speed[k])
      );
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      out_tdata_nxt[SPEED_W*k +: SPEED_W] = speed[k];
    end
  end

  // Output register: a finished result waits here until its transfer.
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.fin) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A period in flight blocks the next one.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a period is in flight");

  // The fill level never passes the ring depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(HISTORY_DEPTH))
    else $error("fill level beyond ring depth");

  // A finished result is shown in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.fin |=> out_tvalid_r)
    else $error("finished result not shown");

endmodule

// ===== test/windowed_encoder_velocity_checker.sv =====
`timescale 1ns / 1ps

module windowed_encoder_velocity_checker #(
  parameter int unsigned IN_W  = 152,
  parameter int unsigned OUT_W = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // From bit 0: count_wheel0 .. count_wheel3, elapsed_us, zero fill.
  input  logic [IN_W-1:0]                in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // From bit 0: short_speed0 .. short_speed3, long_speed0 .. long_speed3.
  input  logic [OUT_W-1:0]               out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wev_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wev_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [wev_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input  logic                           cfg_pready,
  output int                             mismatch_count,
  output int                             outstanding
);

  import wev_pkg::*;

  localparam int unsigned DEPTH  = HISTORY_DEPTH_DEF;
  localparam int unsigned WHEELS = WHEEL_COUNT_DEF;

  typedef struct packed {
    logic [WHEELS-1:0][SPEED_W-1:0] short_spd;
    logic [WHEELS-1:0][SPEED_W-1:0] long_spd;
  } speed_set_t;

  // Shadow of the registers, seen on the configuration port.
  logic [MPT_W-1:0] mpt;
  logic [WIN_W-1:0] short_win;
  logic [WIN_W-1:0] long_win;

  // Shadow of the history ring.
  logic [CNT_W-1:0]  count_hist [DEPTH][WHEELS];
  logic [TIME_W-1:0] time_hist [DEPTH];
  logic [TIME_W-1:0] time_sum;
  int unsigned       head;
  int unsigned       fill;

  speed_set_t        expected_speeds [$];
  speed_set_t        want;
  int                errs;
  logic [ELAPSED_W-1:0] elapsed;
  logic [CFG_DATA_W-1:0] reg_want;
  logic              reg_known;
  string             reg_name;

  // Speed of one wheel over a window of past periods, in 2^-16 m/s.
  function automatic logic [SPEED_W-1:0] window_speed(int unsigned wheel,
                                                      logic [WIN_W-1:0] win);
    int unsigned          span;
    int unsigned          older;
    logic [TIME_W-1:0]    dt;
    logic signed [CNT_W:0] delta;
    logic [CNT_W:0]       mag;
    logic [127:0]         num;
    logic [127:0]         den;
    logic [127:0]         quo;
    span = win;
    if (fill <= 1) begin
      span = 0;
    end else if (span > fill - 1) begin
      span = fill - 1;
    end
    if (span == 0) return '0;
    older = (head + DEPTH - span) % DEPTH;
    dt = time_hist[head] - time_hist[older];
    if (dt == 0) return '0;
    // The count difference is exact, one bit wider than a count.
    delta = $signed({count_hist[head][wheel][CNT_W-1], count_hist[head][wheel]})
          - $signed({count_hist[older][wheel][CNT_W-1], count_hist[older][wheel]});
    mag = delta[CNT_W] ? -delta : delta;
    num = 128'(mag) * 128'(mpt);
    num = num * 128'(US_PER_S);
    den = 128'(dt) << FRAC_DROP;
    quo = num / den;
    if (delta[CNT_W]) begin
      if (quo >= 128'h8000_0000) return SPEED_MIN;
      return SPEED_W'(0) - quo[SPEED_W-1:0];
    end
    if (quo > 128'h7FFF_FFFF) return SPEED_MAX;
    return quo[SPEED_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mpt       = MPT_RESET;
      short_win = SHORT_WIN_RESET;
      long_win  = LONG_WIN_RESET;
      time_sum  = '0;
      head      = 0;
      fill      = 0;
      errs      = 0;
      expected_speeds.delete();
    end else begin
      // Result transfer: compare with the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (expected_speeds.size() == 0) begin
          $error("result transfer with no period outstanding");
          errs++;
        end else begin
          want = expected_speeds.pop_front();
          for (int w = 0; w < WHEELS; w++) begin
            if (out_tdata[SPEED_W*w +: SPEED_W] !== want.short_spd[w]) begin
              $error("short_speed%0d: expected %0d, actual %0d", w,
                     $signed(want.short_spd[w]),
                     $signed(out_tdata[SPEED_W*w +: SPEED_W]));
              errs++;
            end
            if (out_tdata[SPEED_W*(WHEELS+w) +: SPEED_W] !== want.long_spd[w]) begin
              $error("long_speed%0d: expected %0d, actual %0d", w,
                     $signed(want.long_spd[w]),
                     $signed(out_tdata[SPEED_W*(WHEELS+w) +: SPEED_W]));
              errs++;
            end
          end
        end
      end

      // Input transfer: advance the ring and predict the result.
      if (in_tvalid && in_tready) begin
        elapsed  = in_tdata[CNT_W*WHEELS +: ELAPSED_W];
        time_sum = time_sum + TIME_W'(elapsed);
        head     = (head + 1) % DEPTH;
        for (int w = 0; w < WHEELS; w++) begin
          count_hist[head][w] = in_tdata[CNT_W*w +: CNT_W];
        end
        time_hist[head] = time_sum;
        if (fill < DEPTH) fill++;
        for (int w = 0; w < WHEELS; w++) begin
          want.short_spd[w] = window_speed(w, short_win);
          want.long_spd[w]  = window_speed(w, long_win);
        end
        expected_speeds.push_back(want);
      end

      // Register access phase: track writes, check reads.
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[1:0] == 2'b00) begin
        reg_known = 1'b1;
        case (cfg_reg_t'(cfg_paddr[3:2]))
          REG_MPT: begin
            reg_name = "meters_per_tick";
            if (cfg_pwrite) mpt = cfg_pwdata[MPT_W-1:0];
            reg_want = CFG_DATA_W'(mpt);
          end
          REG_SHORT_WIN: begin
            reg_name = "short_window";
            if (cfg_pwrite) short_win = cfg_pwdata[WIN_W-1:0];
            reg_want = CFG_DATA_W'(short_win);
          end
          REG_LONG_WIN: begin
            reg_name = "long_window";
            if (cfg_pwrite) long_win = cfg_pwdata[WIN_W-1:0];
            reg_want = CFG_DATA_W'(long_win);
          end
          default: begin
            reg_known = 1'b0;
          end
        endcase
        if (!cfg_pwrite && reg_known && cfg_prdata !== reg_want) begin
          $error("%s read: expected %0d, actual %0d", reg_name, reg_want, cfg_prdata);
          errs++;
        end
      end
    end
    mismatch_count <= errs;
    outstanding    <= expected_speeds.size();
  end

endmodule

// ===== test/windowed_encoder_velocity_tb.sv =====
`timescale 1ns / 1ps

module windowed_encoder_velocity_tb;
  import wev_pkg::*;

  localparam int unsigned WHEELS = WHEEL_COUNT_DEF;
  localparam int unsigned IN_W   = ((CNT_W * WHEELS + ELAPSED_W + 7) / 8) * 8;
  localparam int unsigned OUT_W  = 2 * WHEELS * SPEED_W;

  localparam logic [CFG_ADDR_W-1:0] ADDR_MPT   = {REG_MPT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SHORT = {REG_SHORT_WIN, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_LONG  = {REG_LONG_WIN, 2'b00};
  // First word past the register list.
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = 4'hC;

  localparam int unsigned LIMIT_CYCLES  = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS   = 75;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'd100000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // From bit 0: count_wheel0 .. count_wheel3, elapsed_us, zero fill.
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // From bit 0: short_speed0 .. short_speed3, long_speed0 .. long_speed3.
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int                    mismatch_count;
  int                    outstanding;
  int unsigned           cycle_count = 0;
  bit                    gaps_on = 1'b1;
  int unsigned           ready_hold = 0;
  logic [CNT_W-1:0]      wheel_pos [WHEELS];

  windowed_encoder_velocity u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  windowed_encoder_velocity_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #2 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("windowed_encoder_velocity verification failed");
      $finish;
    end
  end

  // Length of an idle stretch: mostly short, a few long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(4, 1);
    if (r < 95) return $urandom_range(60, 5);
    return $urandom_range(250, 100);
  endfunction

  // Result side: random back-pressure while gaps are enabled.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (gaps_on && $urandom_range(99) < 30) begin
      out_tready <= 1'b0;
      ready_hold <= idle_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One configuration port transfer, write or read.
  task automatic cfg_access(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_back_all();
    cfg_access(1'b0, ADDR_MPT, '0);
    cfg_access(1'b0, ADDR_SHORT, '0);
    cfg_access(1'b0, ADDR_LONG, '0);
  endtask

  // Window registers get random upper bits, which the block must drop.
  task automatic set_registers(input logic [MPT_W-1:0] mpt_val,
                               input logic [WIN_W-1:0] short_val,
                               input logic [WIN_W-1:0] long_val);
    logic [CFG_DATA_W-1:0] data;
    cfg_access(1'b1, ADDR_MPT, mpt_val);
    data = $urandom();
    data[WIN_W-1:0] = short_val;
    cfg_access(1'b1, ADDR_SHORT, data);
    data = $urandom();
    data[WIN_W-1:0] = long_val;
    cfg_access(1'b1, ADDR_LONG, data);
    read_back_all();
  endtask

  // Drop valid and hold off until every predicted result has been taken.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One control period on the input channel.
  task automatic send_period(input logic [CNT_W-1:0] c0, input logic [CNT_W-1:0] c1,
                             input logic [CNT_W-1:0] c2, input logic [CNT_W-1:0] c3,
                             input logic [ELAPSED_W-1:0] el);
    if (gaps_on && $urandom_range(99) < 40) begin
      in_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    in_tdata  <= IN_W'({el, c3, c2, c1, c0});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly plausible wheel motion, some arbitrary counts, some extremes.
  task automatic random_period();
    int unsigned mode;
    logic [ELAPSED_W-1:0] el;
    mode = $urandom_range(99);
    if (mode < 70) begin
      for (int w = 0; w < WHEELS; w++) begin
        if ($urandom_range(19) == 0) begin
          wheel_pos[w] = wheel_pos[w] + $urandom();
        end else begin
          wheel_pos[w] = wheel_pos[w] + CNT_W'($urandom_range(8000)) - CNT_W'(4000);
        end
      end
      if ($urandom_range(9) == 0) begin
        el = ELAPSED_W'($urandom_range(ELAPSED_MAX));
      end else begin
        el = ELAPSED_W'($urandom_range(11000, 9000));
      end
    end else if (mode < 90) begin
      for (int w = 0; w < WHEELS; w++) begin
        wheel_pos[w] = $urandom();
      end
      el = ELAPSED_W'($urandom_range(ELAPSED_MAX));
    end else begin
      for (int w = 0; w < WHEELS; w++) begin
        case ($urandom_range(3))
          0: wheel_pos[w] = 32'h8000_0000;
          1: wheel_pos[w] = 32'h7FFF_FFFF;
          2: wheel_pos[w] = '0;
          default: wheel_pos[w] = '1;
        endcase
      end
      case ($urandom_range(2))
        0: el = '0;
        1: el = 17'd1;
        default: el = ELAPSED_MAX;
      endcase
    end
    send_period(wheel_pos[0], wheel_pos[1], wheel_pos[2], wheel_pos[3], el);
  endtask

  initial begin
    logic [MPT_W-1:0] mpt_val;
    logic [WIN_W-1:0] short_val;
    logic [WIN_W-1:0] long_val;
    for (int w = 0; w < WHEELS; w++) wheel_pos[w] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_back_all();

    // Reset settings: empty and short history, zero and extreme time steps,
    // full-range count jumps that saturate.
    send_period(32'd0, 32'd0, 32'd0, 32'd0, 17'd10000);
    send_period(32'd1000, -32'sd1000, 32'h7FFF_FFFF, 32'h8000_0000, 17'd10000);
    send_period(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 17'd0);
    send_period(32'h8000_0005, 32'h8000_0004, 32'd4, 32'd5, ELAPSED_MAX);
    send_period(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1, 17'd1);
    send_period(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1, 17'h10000);
    send_period(32'd12345, -32'sd12345, 32'd99999, -32'sd99999, 17'd1);
    send_period(32'd12346, -32'sd12346, 32'd100000, -32'sd100000, 17'h0FFFF);
    wait_idle();

    // Largest scale, zero short window, longest long window; the spare
    // address must not disturb anything. Runs the ring past a full turn.
    set_registers(32'hFFFF_FFFF, 4'd0, 4'd15);
    cfg_access(1'b1, ADDR_SPARE, $urandom());
    read_back_all();
    for (int i = 0; i < 17; i++) begin
      send_period((i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000,
                  (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                  CNT_W'(i * 7919),
                  CNT_W'(i * 1000),
                  (i % 4 == 0) ? 17'd0 : ELAPSED_W'(i * 3000));
    end
    wait_idle();

    // Random periods under a series of settings.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          mpt_val = '0;
          short_val = 4'd2;
          long_val = 4'd15;
        end
        1: begin
          mpt_val = 32'd1;
          short_val = 4'd15;
          long_val = 4'd1;
        end
        2: begin
          mpt_val = '1;
          short_val = WIN_W'($urandom_range(15));
          long_val = WIN_W'($urandom_range(15));
        end
        default: begin
          mpt_val = $urandom_range(1) ? $urandom() : $urandom_range(2000000, 100000);
          short_val = WIN_W'($urandom_range(15));
          long_val = WIN_W'($urandom_range(15));
        end
      endcase
      set_registers(mpt_val, short_val, long_val);
      gaps_on <= (p % 3 != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 40) wait_idle();
        random_period();
      end
      wait_idle();
    end

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("windowed_encoder_velocity verification clean");
    end else begin
      $display("windowed_encoder_velocity verification failed");
    end
    $finish;
  end

endmodule
